FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define DMIP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define DMIP_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: rtl/dmip_pkg.sv
package dmip_pkg;

    // Input beat: one sample tick for one motor channel.
    typedef struct packed {
        logic               channel;
        logic signed [15:0] target_speed;
        logic [31:0]        pulse_count;
    } t_in_item;

    // Output beat: new duty and measured speed for the channel.
    typedef struct packed {
        logic               out_channel;
        logic [15:0]        duty;
        logic signed [31:0] measured_speed;
    } t_out_item;

    // Configuration register file contents.
    typedef struct packed {
        logic [15:0] gain_prop;
        logic [15:0] gain_deriv;
        logic [15:0] gain_integ;
        logic [9:0]  sample_ms;
        logic [9:0]  inv_sample;
        logic [15:0] pwm_span;
    } t_cfg;

    localparam int CFG_IDX_W = 3;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_PROP  = 3'd0,
        CFG_GAIN_DERIV = 3'd1,
        CFG_GAIN_INTEG = 3'd2,
        CFG_SAMPLE_MS  = 3'd3,
        CFG_INV_SAMPLE = 3'd4,
        CFG_PWM_SPAN   = 3'd5
    } t_cfg_reg;

    // Register values after reset.
    localparam logic [15:0] RST_GAIN_PROP  = 16'd10;
    localparam logic [15:0] RST_GAIN_DERIV = 16'd10;
    localparam logic [15:0] RST_GAIN_INTEG = 16'd1;
    localparam logic [9:0]  RST_SAMPLE_MS  = 10'd25;
    localparam logic [9:0]  RST_INV_SAMPLE = 10'd40;
    localparam logic [15:0] RST_PWM_SPAN   = 16'd8400;

    // Division by 1000 as a multiply by ceil(2^38 / 1000) and a shift by 38.
    // The magnitude is split in 16-bit halves, so the shift after the
    // partial products are combined is 38 - 16.
    localparam logic [28:0] RECIP_1000 = 29'd274877907;
    localparam int          PART_SHIFT = 16;
    localparam int          QUOT_SHIFT = 22;
    localparam int          QH_W       = 45;
    localparam int          QSUM_W     = 46;

    // Microprogram counter.
    localparam int                 STEP_W   = 4;
    localparam logic [STEP_W-1:0]  PROG_LEN = 4'd13;

    // Multiplier operand pairs.
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_GI_SM,
        MUL_P_ERR,
        MUL_GD_T,
        MUL_P_INV,
        MUL_GP_ERR,
        MUL_MHI_RCP,
        MUL_MLO_RCP
    } t_mul_op;

    // Adder and register-transfer operations.
    typedef enum logic [3:0] {
        ALU_NOP,
        ALU_SPEED,
        ALU_ERR,
        ALU_DIFF,
        ALU_ABS,
        ALU_LOAD_DUTY,
        ALU_ACC_PROD,
        ALU_SAVE_QH,
        ALU_QUOT,
        ALU_INTEG,
        ALU_ACC_INT,
        ALU_COMMIT
    } t_alu_op;

    // Sequencing: fall through, branch to target while the output is
    // blocked, or end the program.
    typedef enum logic [1:0] {
        JC_NEXT,
        JC_BLOCKED,
        JC_DONE
    } t_jcond;

    // One microcode word.
    typedef struct packed {
        t_mul_op           mul;
        t_alu_op           alu;
        t_jcond            jump;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    function automatic t_ctrl make_ctrl(t_mul_op m, t_alu_op a, t_jcond j,
                                        logic [STEP_W-1:0] t);
        t_ctrl w;
        w.mul    = m;
        w.alu    = a;
        w.jump   = j;
        w.target = t;
        return w;
    endfunction

endpackage

FILE: rtl/dual_motor_incremental_pid.sv
// An accepted input beat runs through the 13 microcode steps and then the output register
// to its output beat, and holds at step 11 while an earlier result waits to be taken.
// A new beat is taken only once the microprogram on the shared 32x32 multiplier has ended.
// A beat for a channel that is not present is taken while idle and gives no result.
// Reset (synchronous, active low) clears all channel state and loads the register defaults.
module dual_motor_incremental_pid #(
    parameter int NUM_CHANNELS = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  dmip_pkg::t_in_item                i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output dmip_pkg::t_out_item               o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dmip_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [15:0]                       i_cfg_data
);

    dmip_pkg::t_cfg  r_cfg;
    dmip_pkg::t_ctrl w_ctrl;
    logic            w_present;
    logic            w_exec;
    logic            w_out_blocked;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_prop  <= dmip_pkg::RST_GAIN_PROP;
            r_cfg.gain_deriv <= dmip_pkg::RST_GAIN_DERIV;
            r_cfg.gain_integ <= dmip_pkg::RST_GAIN_INTEG;
            r_cfg.sample_ms  <= dmip_pkg::RST_SAMPLE_MS;
            r_cfg.inv_sample <= dmip_pkg::RST_INV_SAMPLE;
            r_cfg.pwm_span   <= dmip_pkg::RST_PWM_SPAN;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dmip_pkg::CFG_GAIN_PROP:  r_cfg.gain_prop  <= i_cfg_data;
                dmip_pkg::CFG_GAIN_DERIV: r_cfg.gain_deriv <= i_cfg_data;
                dmip_pkg::CFG_GAIN_INTEG: r_cfg.gain_integ <= i_cfg_data;
                dmip_pkg::CFG_SAMPLE_MS:  r_cfg.sample_ms  <= i_cfg_data[9:0];
                dmip_pkg::CFG_INV_SAMPLE: r_cfg.inv_sample <= i_cfg_data[9:0];
                dmip_pkg::CFG_PWM_SPAN:   r_cfg.pwm_span   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Only channels that exist start the program.
    assign w_present = (32'(i_in.channel) < 32'(NUM_CHANNELS));

    dmip_sequencer u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_present  (w_present),
        .i_out_blocked (w_out_blocked),
        .o_in_ready    (o_in_ready),
        .o_exec        (w_exec),
        .o_ctrl        (w_ctrl)
    );

    dmip_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_accept   (i_in_valid && o_in_ready),
        .i_in          (i_in),
        .i_exec        (w_exec),
        .i_ctrl        (w_ctrl),
        .i_cfg         (r_cfg),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_out         (o_out),
        .o_out_blocked (w_out_blocked)
    );

endmodule

FILE: rtl/dmip_ucode_rom.sv
module dmip_ucode_rom (
    input  logic [dmip_pkg::STEP_W-1:0] i_step,
    output dmip_pkg::t_ctrl             o_ctrl
);

    // The PID program. A product issued at one step is in the product
    // register at the next step.
    always_comb begin
        unique case (i_step)
            4'd0:  o_ctrl = dmip_pkg::make_ctrl(dmip_pkg::MUL_NONE, dmip_pkg::ALU_SPEED,
                                                dmip_pkg::JC_NEXT, 4'd0);
            4'd1:  o_ctrl = dmip_pkg::make_ctrl(dmip_pkg::MUL_GI_SM, dmip_pkg::ALU_ERR,
                                                dmip_pkg::JC_NEXT, 4'd0);
            4'd2:  o_ctrl = dmip_pkg::make_ctrl(dmip_pkg::MUL_P_ERR, dmip_pkg::ALU_DIFF,
                                                dmip_pkg::JC_NEXT, 4'd0);
            4'd3:  o_ctrl = dmip_pkg::make_ctrl(dmip_pkg::MUL_GD_T, dmip_pkg::ALU_ABS,
                                                dmip_pkg::JC_NEXT, 4'd0);
            4'd4:  o_ctrl = dmip_pkg::make_ctrl(dmip_pkg::MUL_P_INV, dmip_pkg::ALU_LOAD_DUTY,
                                                dmip_pkg::JC_NEXT, 4'd0);
            4'd5:  o_ctrl = dmip_pkg::make_ctrl(dmip_pkg::MUL_GP_ERR, dmip_pkg::ALU_ACC_PROD,
                                                dmip_pkg::JC_NEXT, 4'd0);
            4'd6:  o_ctrl = dmip_pkg::make_ctrl(dmip_pkg::MUL_MHI_RCP, dmip_pkg::ALU_ACC_PROD,
                                                dmip_pkg::JC_NEXT, 4'd0);
            4'd7:  o_ctrl = dmip_pkg::make_ctrl(dmip_pkg::MUL_MLO_RCP, dmip_pkg::ALU_SAVE_QH,
                                                dmip_pkg::JC_NEXT, 4'd0);
            4'd8:  o_ctrl = dmip_pkg::make_ctrl(dmip_pkg::MUL_NONE, dmip_pkg::ALU_QUOT,
                                                dmip_pkg::JC_NEXT, 4'd0);
            4'd9:  o_ctrl = dmip_pkg::make_ctrl(dmip_pkg::MUL_NONE, dmip_pkg::ALU_INTEG,
                                                dmip_pkg::JC_NEXT, 4'd0);
            4'd10: o_ctrl = dmip_pkg::make_ctrl(dmip_pkg::MUL_NONE, dmip_pkg::ALU_ACC_INT,
                                                dmip_pkg::JC_NEXT, 4'd0);
            4'd11: o_ctrl = dmip_pkg::make_ctrl(dmip_pkg::MUL_NONE, dmip_pkg::ALU_NOP,
                                                dmip_pkg::JC_BLOCKED, 4'd11);
            4'd12: o_ctrl = dmip_pkg::make_ctrl(dmip_pkg::MUL_NONE, dmip_pkg::ALU_COMMIT,
                                                dmip_pkg::JC_DONE, 4'd0);
            default: o_ctrl = dmip_pkg::make_ctrl(dmip_pkg::MUL_NONE, dmip_pkg::ALU_NOP,
                                                  dmip_pkg::JC_DONE, 4'd0);
        endcase
    end

endmodule

FILE: rtl/dmip_sequencer.sv
`include "assert_macros.svh"

module dmip_sequencer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_present,
    input  logic            i_out_blocked,
    output logic            o_in_ready,
    output logic            o_exec,
    output dmip_pkg::t_ctrl o_ctrl
);

    logic                          r_busy;
    logic                          n_busy;
    logic [dmip_pkg::STEP_W-1:0]   r_step;
    logic [dmip_pkg::STEP_W-1:0]   n_step;
    dmip_pkg::t_ctrl               w_ctrl;

    // Control store lookup for the current step.
    dmip_ucode_rom u_rom (
        .i_step (r_step),
        .o_ctrl (w_ctrl)
    );

    // Next step: start on a beat for a present channel, then follow the
    // jump field of each control word.
    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (!r_busy) begin
            if (i_in_valid && i_in_present) begin
                n_busy = 1'b1;
                n_step = '0;
            end
        end else begin
            unique case (w_ctrl.jump)
                dmip_pkg::JC_NEXT: begin
                    n_step = r_step + 1'b1;
                end
                dmip_pkg::JC_BLOCKED: begin
                    n_step = i_out_blocked ? w_ctrl.target : r_step + 1'b1;
                end
                dmip_pkg::JC_DONE: begin
                    n_busy = 1'b0;
                    n_step = '0;
                end
                default: begin
                    n_busy = 1'b0;
                    n_step = '0;
                end
            endcase
        end
    end

    // Outputs toward the handshake and the datapath.
    always_comb begin
        o_in_ready = !r_busy;
        o_exec     = r_busy;
        o_ctrl     = w_ctrl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    // The commit step must only be reached with a free output register.
    `DMIP_ASSERT(a_commit_free, i_clk, i_rst_n, (r_busy && w_ctrl.alu == dmip_pkg::ALU_COMMIT) |-> !i_out_blocked, "commit while output register is blocked")
    // The step counter stays inside the program.
    `DMIP_ASSERT(a_step_range, i_clk, i_rst_n, r_busy |-> (r_step < dmip_pkg::PROG_LEN), "step counter left the program")

endmodule

FILE: rtl/dmip_datapath.sv
`include "assert_macros.svh"

module dmip_datapath #(
    parameter int NUM_CHANNELS = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_accept,
    input  dmip_pkg::t_in_item  i_in,
    input  logic                i_exec,
    input  dmip_pkg::t_ctrl     i_ctrl,
    input  dmip_pkg::t_cfg      i_cfg,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output dmip_pkg::t_out_item o_out,
    output logic                o_out_blocked
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // Per-channel controller state.
    logic [31:0] r_last_count [NUM_CHANNELS];
    logic [31:0] r_last_error [NUM_CHANNELS];
    logic [31:0] r_integ_sum  [NUM_CHANNELS];
    logic [31:0] r_duty_value [NUM_CHANNELS];

    // Captured sample.
    logic [CH_W-1:0]    r_ch;
    logic               r_ch_bit;
    logic signed [15:0] r_tgt;
    logic [31:0]        r_cnt;

    // Working registers.
    logic [31:0]                 r_spd;
    logic [31:0]                 r_err;
    logic [31:0]                 r_t;
    logic [31:0]                 r_acc;
    logic [31:0]                 r_mag;
    logic                        r_neg;
    logic [31:0]                 r_int;
    logic [dmip_pkg::QH_W-1:0]   r_qh;
    logic [63:0]                 r_prod;

    logic                        r_out_valid;
    dmip_pkg::t_out_item         r_out;

    logic [31:0]                 w_mul_a;
    logic [31:0]                 w_mul_b;
    logic [dmip_pkg::QSUM_W-1:0] w_qsum;
    logic signed [31:0]          w_acc_s;
    logic signed [31:0]          w_period;
    logic signed [31:0]          w_hi;
    logic signed [31:0]          w_duty;
    logic                        w_commit;

    assign w_commit = i_exec && (i_ctrl.alu == dmip_pkg::ALU_COMMIT);

    // Multiplier operand selection.
    always_comb begin
        unique case (i_ctrl.mul)
            dmip_pkg::MUL_GI_SM: begin
                w_mul_a = 32'(i_cfg.gain_integ);
                w_mul_b = 32'(i_cfg.sample_ms);
            end
            dmip_pkg::MUL_P_ERR: begin
                w_mul_a = r_prod[31:0];
                w_mul_b = r_err;
            end
            dmip_pkg::MUL_GD_T: begin
                w_mul_a = 32'(i_cfg.gain_deriv);
                w_mul_b = r_t;
            end
            dmip_pkg::MUL_P_INV: begin
                w_mul_a = r_prod[31:0];
                w_mul_b = 32'(i_cfg.inv_sample);
            end
            dmip_pkg::MUL_GP_ERR: begin
                w_mul_a = 32'(i_cfg.gain_prop);
                w_mul_b = r_err;
            end
            dmip_pkg::MUL_MHI_RCP: begin
                w_mul_a = 32'(r_mag[31:16]);
                w_mul_b = 32'(dmip_pkg::RECIP_1000);
            end
            dmip_pkg::MUL_MLO_RCP: begin
                w_mul_a = 32'(r_mag[15:0]);
                w_mul_b = 32'(dmip_pkg::RECIP_1000);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Quotient by 1000: high partial product plus the shifted low one.
    assign w_qsum = dmip_pkg::QSUM_W'(r_qh)
                  + dmip_pkg::QSUM_W'(r_prod[63:dmip_pkg::PART_SHIFT]);

    // Duty clamp: limit from above to period-1 first, then from below to 1.
    always_comb begin
        w_acc_s  = signed'(r_acc);
        w_period = signed'({16'd0, i_cfg.pwm_span});
        w_hi     = (w_acc_s >= w_period) ? w_period - 32'sd1 : w_acc_s;
        w_duty   = (w_hi <= 32'sd0) ? 32'sd1 : w_hi;
    end

    // Sample capture, multiplier and working registers.
    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_ch     <= CH_W'(i_in.channel);
            r_ch_bit <= i_in.channel;
            r_tgt    <= i_in.target_speed;
            r_cnt    <= i_in.pulse_count;
        end
        if (i_exec && i_ctrl.mul != dmip_pkg::MUL_NONE) begin
            r_prod <= 64'(w_mul_a) * 64'(w_mul_b);
        end
        if (i_exec) begin
            unique case (i_ctrl.alu)
                dmip_pkg::ALU_SPEED:     r_spd <= r_cnt - r_last_count[r_ch];
                dmip_pkg::ALU_ERR:       r_err <= 32'(r_tgt) - r_spd;
                dmip_pkg::ALU_DIFF:      r_t   <= r_err - r_last_error[r_ch];
                dmip_pkg::ALU_ABS: begin
                    r_neg <= r_prod[31];
                    r_mag <= r_prod[31] ? (~r_prod[31:0] + 32'd1) : r_prod[31:0];
                end
                dmip_pkg::ALU_LOAD_DUTY: r_acc <= r_duty_value[r_ch];
                dmip_pkg::ALU_ACC_PROD:  r_acc <= r_acc + r_prod[31:0];
                dmip_pkg::ALU_SAVE_QH:   r_qh  <= r_prod[dmip_pkg::QH_W-1:0];
                dmip_pkg::ALU_QUOT:      r_t   <= 32'(w_qsum[dmip_pkg::QSUM_W-1:dmip_pkg::QUOT_SHIFT]);
                dmip_pkg::ALU_INTEG:     r_int <= r_integ_sum[r_ch] + (r_t ^ {32{r_neg}})
                                                  + 32'(r_neg);
                dmip_pkg::ALU_ACC_INT:   r_acc <= r_acc + r_int;
                dmip_pkg::ALU_COMMIT: begin
                    r_out.out_channel    <= r_ch_bit;
                    r_out.duty           <= w_duty[15:0];
                    r_out.measured_speed <= signed'(r_spd);
                end
                default: begin
                end
            endcase
        end
    end

    // Channel state is written back when the result is committed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_last_count[i] <= '0;
                r_last_error[i] <= '0;
                r_integ_sum[i]  <= '0;
                r_duty_value[i] <= '0;
            end
        end else if (w_commit) begin
            r_last_count[r_ch] <= r_cnt;
            r_last_error[r_ch] <= r_err;
            r_integ_sum[r_ch]  <= r_int;
            r_duty_value[r_ch] <= unsigned'(w_duty);
        end
    end

    // Output register: set by a commit, cleared when the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out         = r_out;
    assign o_out_blocked = r_out_valid && !i_out_ready;

    // A committed result is offered on the next cycle.
    `DMIP_ASSERT(a_commit_shows, i_clk, i_rst_n, w_commit |=> r_out_valid, "commit did not raise the output valid")
    // The clamp never lets a zero duty out.
    `DMIP_NEVER(a_duty_nonzero, i_clk, i_rst_n, r_out_valid && r_out.duty == 16'd0, "zero duty offered")

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import dmip_pkg::*;

    // Register indexes past the end of the register list.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    // Cycles with no accepted beat on any channel before the run is abandoned.
    localparam int STALL_LIMIT     = 4000;
    // Upper bound on the final wait for outstanding results.
    localparam int DRAIN_LIMIT     = 3000;
    // Cycles waited after the last result before the final checks.
    localparam int SETTLE_CYCLES   = 20;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int NUM_PHASES      = 8;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in_item    in_data;
    logic        out_valid;
    logic        out_ready;
    t_out_item   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0] cfg_data;

    // Predictor copy of the register file and the per-channel loop state.
    t_cfg        pid_cfg;
    bit [31:0]   prev_count [2];
    bit [31:0]   prev_error [2];
    bit [31:0]   integ_acc [2];
    bit [31:0]   duty_acc [2];

    // Duty results still owed by the block, oldest first.
    t_out_item   duty_expect_q [$];

    // Encoder position used to build plausible sample sequences.
    bit [31:0]   enc_pos [2];

    bit          tx_gaps_on;
    bit          rx_stalls_on;
    int          fail_count;
    int          samples_sent;
    int          results_checked;
    int          reg_writes;
    int          clamp_high_cnt;
    int          clamp_low_cnt;
    t_out_item   want;

    dual_motor_incremental_pid i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Free-running clock.
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Prints one failure line and counts it.
    task automatic report_failure(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // Mostly short idle stretches, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(15, 50);
    endfunction

    // Loads the register defaults and clears the channel state, as reset does.
    function automatic void reset_predictor();
        pid_cfg.gain_prop  = RST_GAIN_PROP;
        pid_cfg.gain_deriv = RST_GAIN_DERIV;
        pid_cfg.gain_integ = RST_GAIN_INTEG;
        pid_cfg.sample_ms  = RST_SAMPLE_MS;
        pid_cfg.inv_sample = RST_INV_SAMPLE;
        pid_cfg.pwm_span   = RST_PWM_SPAN;
        for (int c = 0; c < 2; c++) begin
            prev_count[c] = '0;
            prev_error[c] = '0;
            integ_acc[c]  = '0;
            duty_acc[c]   = '0;
        end
    endfunction

    // Mirrors one register write; indexes past the list change nothing.
    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        case (idx)
            CFG_GAIN_PROP:  pid_cfg.gain_prop  = data;
            CFG_GAIN_DERIV: pid_cfg.gain_deriv = data;
            CFG_GAIN_INTEG: pid_cfg.gain_integ = data;
            CFG_SAMPLE_MS:  pid_cfg.sample_ms  = data[9:0];
            CFG_INV_SAMPLE: pid_cfg.inv_sample = data[9:0];
            CFG_PWM_SPAN:   pid_cfg.pwm_span   = data;
            default: ;
        endcase
    endfunction

    // One incremental PID step for the sample's channel. All products wrap at
    // 32 bits; the integral division truncates toward zero.
    function automatic t_out_item predict_duty(t_in_item s);
        t_out_item r;
        int        ch;
        int        quot;
        bit [31:0] tgt, speed, err, prop, deriv, integ_prod, duty, limit;
        bit [31:0] gp, gd, gi, sm, inv;
        ch    = int'(s.channel);
        gp    = 32'(pid_cfg.gain_prop);
        gd    = 32'(pid_cfg.gain_deriv);
        gi    = 32'(pid_cfg.gain_integ);
        sm    = 32'(pid_cfg.sample_ms);
        inv   = 32'(pid_cfg.inv_sample);
        limit = 32'(pid_cfg.pwm_span);
        tgt   = {{16{s.target_speed[15]}}, s.target_speed};

        speed          = s.pulse_count - prev_count[ch];
        prev_count[ch] = s.pulse_count;
        err            = tgt - speed;
        prop           = gp * err;
        deriv          = gd * (err - prev_error[ch]) * inv;
        integ_prod     = gi * sm * err;
        quot           = $signed(integ_prod) / 1000;
        integ_acc[ch]  = integ_acc[ch] + quot;
        duty           = duty_acc[ch] + prop + deriv + integ_acc[ch];

        // Upper clamp first, then the lower one, both as signed compares.
        if ($signed(duty) >= $signed(limit)) begin
            duty = limit - 32'd1;
            clamp_high_cnt++;
        end
        if ($signed(duty) < 32'sd1) begin
            duty = 32'd1;
            clamp_low_cnt++;
        end
        duty_acc[ch]   = duty;
        prev_error[ch] = err;

        r.out_channel    = s.channel;
        r.duty           = duty[15:0];
        r.measured_speed = speed;
        return r;
    endfunction

    function automatic t_in_item mk_sample(bit ch, logic [15:0] tgt, logic [31:0] cnt);
        t_in_item s;
        s.channel      = ch;
        s.target_speed = tgt;
        s.pulse_count  = cnt;
        return s;
    endfunction

    // Mostly a well-behaved encoder that moves by about the target each tick,
    // the rest arbitrary targets and counts.
    function automatic t_in_item next_random_sample();
        t_in_item s;
        int       tgt;
        int       slip;
        s.channel = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 85) begin
            if ($urandom_range(0, 9) == 0) begin
                tgt = $urandom_range(0, 65535) - 32768;
            end else begin
                tgt = $urandom_range(0, 4000) - 2000;
            end
            slip = $urandom_range(0, 40) - 20;
            if ($urandom_range(0, 19) == 0) begin
                slip = $urandom_range(0, 20000) - 10000;
            end
            enc_pos[s.channel] = enc_pos[s.channel] + tgt + slip;
            s.target_speed = tgt[15:0];
        end else begin
            s.target_speed     = 16'($urandom);
            enc_pos[s.channel] = $urandom;
        end
        s.pulse_count = enc_pos[s.channel];
        return s;
    endfunction

    // Sends one sample beat, records its prediction, then idles a random while if gaps are on.
    task automatic send_sample(t_in_item s);
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= s;
        do @(posedge clk); while (!in_ready);
        duty_expect_q.push_back(predict_duty(s));
        samples_sent++;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Drops the sample valid and waits for every owed result.
    task automatic quiesce();
        @(negedge clk) in_valid <= 1'b0;
        while (duty_expect_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes one register over the configuration channel.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        apply_register(idx, data);
        reg_writes++;
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    task automatic write_all_regs(logic [15:0] gp, logic [15:0] gd, logic [15:0] gi,
                                  logic [15:0] sm, logic [15:0] inv, logic [15:0] per);
        write_register(CFG_GAIN_PROP, gp);
        write_register(CFG_GAIN_DERIV, gd);
        write_register(CFG_GAIN_INTEG, gi);
        write_register(CFG_SAMPLE_MS, sm);
        write_register(CFG_INV_SAMPLE, inv);
        write_register(CFG_PWM_SPAN, per);
    endtask

    // Register defaults straight out of reset, including a negative error
    // whose integral share truncates toward zero.
    task automatic test_reset_defaults();
        send_sample(mk_sample(1'b0, 16'sd100, 32'd90));
        send_sample(mk_sample(1'b1, -16'sd100, 32'd0));
        send_sample(mk_sample(1'b0, 16'sd100, 32'd180));
        send_sample(mk_sample(1'b1, -16'sd39, 32'd0));
    endtask

    // Field extremes: largest targets of both signs and counts that wrap.
    task automatic test_field_extremes();
        send_sample(mk_sample(1'b0, 16'h7FFF, 32'hFFFF_FFFF));
        send_sample(mk_sample(1'b0, 16'h8000, 32'h0000_0000));
        send_sample(mk_sample(1'b1, 16'h8000, 32'h8000_0000));
        send_sample(mk_sample(1'b1, 16'h7FFF, 32'h7FFF_FFFF));
        send_sample(mk_sample(1'b0, 16'h0000, 32'h7FFF_FFFF));
        send_sample(mk_sample(1'b0, 16'hFFFF, 32'h8000_0000));
        send_sample(mk_sample(1'b1, 16'h0001, 32'h7FFF_FFFE));
    endtask

    // Register extremes: wrapping gains, out-of-range sample values cut to their low
    // 10 bits, writes past the list, and periods of zero and one that force duty 1.
    task automatic test_register_extremes();
        quiesce();
        write_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_register(CFG_IDX_SPARE_LO, 16'h0000);
        write_register(CFG_IDX_SPARE_HI, 16'hFFFF);
        send_sample(mk_sample(1'b0, 16'sd1000, 32'h1234_5678));
        send_sample(mk_sample(1'b1, -16'sd1000, 32'hFEDC_BA98));
        send_sample(mk_sample(1'b0, 16'sd5, 32'h1234_567A));

        quiesce();
        write_register(CFG_PWM_SPAN, 16'd0);
        send_sample(mk_sample(1'b0, 16'sd300, 32'h1234_5700));
        send_sample(mk_sample(1'b1, -16'sd300, 32'hFEDC_B000));

        quiesce();
        write_register(CFG_PWM_SPAN, 16'd1);
        send_sample(mk_sample(1'b0, 16'sd300, 32'h1234_5800));

        quiesce();
        write_all_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd2);
        send_sample(mk_sample(1'b1, 16'sd7, 32'hFEDC_B010));
        send_sample(mk_sample(1'b0, 16'sd7, 32'h1234_5808));
    endtask

    // Random sample streams across several register settings, with and
    // without idling, and in even phases a mid-phase pause until the block runs dry.
    task automatic test_random_phases();
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            quiesce();
            case (ph)
                0: write_all_regs(RST_GAIN_PROP, RST_GAIN_DERIV, RST_GAIN_INTEG,
                                  16'(RST_SAMPLE_MS), 16'(RST_INV_SAMPLE), RST_PWM_SPAN);
                1: write_all_regs(16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'hFFFF);
                2: write_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1000, 16'd1000,
                                  16'hFFFF);
                3: write_all_regs(16'd1, 16'd1, 16'd1, 16'd1000, 16'd1, 16'd2);
                default: write_all_regs(16'($urandom_range(0, 64)),
                                        16'($urandom_range(0, 64)),
                                        16'($urandom_range(0, 64)),
                                        16'($urandom_range(1, 1000)),
                                        16'($urandom_range(1, 1000)),
                                        16'($urandom_range(2, 65535)));
            endcase
            tx_gaps_on   = (ph != 4);
            rx_stalls_on = (ph != 4) && (ph != 6);
            enc_pos[0]   = $urandom;
            enc_pos[1]   = $urandom;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k == ITEMS_PER_PHASE / 2 && ph % 2 == 0) begin
                    quiesce();
                end
                send_sample(next_random_sample());
            end
        end
    endtask

    // Output ready: random runs of acceptance, broken by stalls while stalls are on.
    initial begin : out_ready_driver
        int run_len;
        int hold;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            run_len = $urandom_range(1, 12);
            @(negedge clk) out_ready <= 1'b1;
            repeat (run_len - 1) @(negedge clk);
            if (rx_stalls_on) begin
                hold = pick_gap();
                if (hold > 0) begin
                    @(negedge clk) out_ready <= 1'b0;
                    repeat (hold - 1) @(negedge clk);
                end
            end
        end
    end

    // Compares each accepted result beat with the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (duty_expect_q.size() == 0) begin
                report_failure($sformatf("result with none owed: ch %0d duty %0d speed %0d",
                               out_data.out_channel, out_data.duty,
                               out_data.measured_speed));
            end else begin
                want = duty_expect_q.pop_front();
                if (out_data.out_channel !== want.out_channel) begin
                    report_failure($sformatf("out_channel got %0d expected %0d",
                                   out_data.out_channel, want.out_channel));
                end
                if (out_data.duty !== want.duty) begin
                    report_failure($sformatf("duty got %0d expected %0d (ch %0d)",
                                   out_data.duty, want.duty, want.out_channel));
                end
                if (out_data.measured_speed !== want.measured_speed) begin
                    report_failure($sformatf("measured_speed got %0d expected %0d (ch %0d)",
                                   out_data.measured_speed, want.measured_speed,
                                   want.out_channel));
                end
            end
            results_checked++;
        end
    end

    // Ends the run if no beat moves on any channel for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Test sequence.
    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        fail_count   = 0;
        reset_predictor();
        repeat (12) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_reset_defaults();
        test_field_extremes();
        test_register_extremes();
        test_random_phases();

        // Drain the remaining results, then let the block settle.
        @(negedge clk) in_valid <= 1'b0;
        for (int w = 0; w < DRAIN_LIMIT && duty_expect_q.size() != 0; w++) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (duty_expect_q.size() != 0) begin
            report_failure($sformatf("%0d results never arrived", duty_expect_q.size()));
        end

        $display("Sent %0d samples on both channels, checked %0d results, %0d register writes.",
                 samples_sent, results_checked, reg_writes);
        $display("Duty reached the upper clamp %0d times and the lower clamp %0d times.",
                 clamp_high_cnt, clamp_low_cnt);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
